>>> rtl/core/bvpc_pkg.sv
// Package for the boundary voxel point collector: widths, codes, payload
// structs, controller/datapath command and status types, ring helpers.
// Depends on nothing; bvpc_dpath, bvpc_ctrl and the top level use it.
package bvpc_pkg;

   // Largest number of cells per chunk axis.
   localparam int MAX_CELLS_PER_AXIS = 32;
   // Solid-bit ring: two full planes plus one sample.
   localparam int WIN_DEPTH = 2 * (MAX_CELLS_PER_AXIS + 1) * (MAX_CELLS_PER_AXIS + 1) + 1;
   localparam int WIN_AW    = $clog2(WIN_DEPTH);
   // Raster position width, able to hold S+1.
   localparam int POS_W     = $clog2(MAX_CELLS_PER_AXIS + 2);
   localparam int PITCH_W   = 24;
   localparam int PROD_W    = POS_W + PITCH_W;
   localparam int WORLD_W   = 34;
   localparam int DIFF_W    = WORLD_W + 1;
   localparam int NB_COUNT  = 6;

   // Item kinds.
   localparam logic [1:0] KIND_BEGIN  = 2'd0;
   localparam logic [1:0] KIND_CHUNK  = 2'd1;
   localparam logic [1:0] KIND_SAMPLE = 2'd2;

   // Configuration register indexes.
   localparam logic [2:0] CSR_CENTER_X = 3'd0;
   localparam logic [2:0] CSR_CENTER_Y = 3'd1;
   localparam logic [2:0] CSR_CENTER_Z = 3'd2;
   localparam logic [2:0] CSR_RADIUS   = 3'd3;
   localparam logic [2:0] CSR_PITCH    = 3'd4;
   localparam logic [2:0] CSR_SAMPLES  = 3'd5;
   localparam logic [2:0] CSR_MAX_PTS  = 3'd6;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic [7:0]         occupancy;
   } req_type;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic               final_point;
   } rsp_type;

   // Datapath operation selected by the controller each cycle.
   typedef enum logic [3:0] {
      STEP_IDLE,
      STEP_READ,
      STEP_PROD,
      STEP_WSUM,
      STEP_DIFF,
      STEP_SQR,
      STEP_ACCUM,
      STEP_RSQ,
      STEP_EMIT
   } step_type;

   typedef struct packed {
      logic       accept;
      step_type   step;
      logic [1:0] axis;
      logic [2:0] rd_sel;
   } cmd_type;

   typedef struct packed {
      logic sample;
      logic go;
      logic in_range;
   } status_type;

   // Ring address arithmetic; both operands are below WIN_DEPTH.
   function automatic logic [WIN_AW-1:0] wrap_add(input logic [WIN_AW-1:0] a,
                                                  input logic [WIN_AW-1:0] b);
      logic [WIN_AW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (WIN_AW + 1)'(WIN_DEPTH)) begin
         s = s - (WIN_AW + 1)'(WIN_DEPTH);
      end
      return s[WIN_AW-1:0];
   endfunction

   function automatic logic [WIN_AW-1:0] wrap_sub(input logic [WIN_AW-1:0] a,
                                                  input logic [WIN_AW-1:0] b);
      logic [WIN_AW:0] s;
      if (a >= b) begin
         s = {1'b0, a} - {1'b0, b};
      end else begin
         s = {1'b0, a} + (WIN_AW + 1)'(WIN_DEPTH) - {1'b0, b};
      end
      return s[WIN_AW-1:0];
   endfunction

endpackage

>>> rtl/core/bvpc_ram.sv
// Generic single-port RAM with a registered read.
// Depends on nothing.
module bvpc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Read-before-write; the read word is registered.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/bvpc_dpath.sv
// Datapath of the boundary voxel point collector: configuration, raster
// position, solid-bit ring, neighbour reads, distance test and result register.
// Depends on bvpc_pkg and bvpc_ram.
module bvpc_dpath (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_wdata,
   input  bvpc_pkg::req_type    req_data,
   input  bvpc_pkg::cmd_type    cmd,
   output bvpc_pkg::status_type status,
   output bvpc_pkg::rsp_type    rsp_data
);

   localparam int AW = bvpc_pkg::WIN_AW;
   localparam int PW = bvpc_pkg::POS_W;
   localparam int WW = bvpc_pkg::WORLD_W;
   localparam int DW = bvpc_pkg::DIFF_W;

   // Configuration registers.
   logic signed [31:0] center_ff [3];
   logic signed [31:0] radius_ff;
   logic [23:0]        pitch_ff;
   logic [5:0]         samples_ff;
   logic [15:0]        max_pts_ff;

   // Raster and chunk state.
   logic [PW-1:0]      pos_x_ff, pos_y_ff, pos_z_ff;
   logic [PW-1:0]      pos_x_in, pos_y_in, pos_z_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic signed [31:0] base_ff [3];
   logic [15:0]        count_ff;
   logic               stopped_ff;

   // Per-sample working registers.
   logic [PW-1:0]                 coord_ff [3];
   logic                          interior_ff;
   logic                          self_ff;
   logic [AW-1:0]                 cell_ff;
   logic [bvpc_pkg::NB_COUNT-1:0] nb_ff;
   logic [bvpc_pkg::PROD_W-1:0]   prod_ff;
   logic signed [WW-1:0]          world_ff [3];
   logic [DW-1:0]                 mag_ff;
   logic [63:0]                   sq_ff;
   logic [63:0]                   acc_ff;
   bvpc_pkg::rsp_type             rsp_ff;

   // Derived chunk geometry.
   logic [PW-1:0] cells;
   logic [PW-1:0] side;
   logic [AW-1:0] side_w;
   logic [AW-1:0] plane_w;

   logic          sample_beat;
   logic          rewind;
   logic [AW-1:0] ram_addr;
   logic [AW-1:0] rd_addr;
   logic [0:0]    ram_rdata;
   logic          solid;
   logic          interior;

   logic signed [DW-1:0] diff;
   logic [31:0]          mul_a;
   logic [63:0]          mul_p;
   logic [64:0]          acc_sum;
   logic [15:0]          count_next;
   logic signed [WW-1:0] wsum;

   assign cells   = (32'(samples_ff) > bvpc_pkg::MAX_CELLS_PER_AXIS)
                    ? PW'(bvpc_pkg::MAX_CELLS_PER_AXIS) : PW'(samples_ff);
   assign side    = cells + PW'(1);
   assign side_w  = AW'(side);
   assign plane_w = AW'(side_w * side_w);

   assign sample_beat = cmd.accept && (req_data.kind == bvpc_pkg::KIND_SAMPLE);
   assign rewind      = (cmd.accept && (req_data.kind == bvpc_pkg::KIND_CHUNK)) ||
                        (csr_we && (csr_index == bvpc_pkg::CSR_SAMPLES));
   assign solid       = (req_data.occupancy != 8'd0);
   assign interior    = (pos_z_ff >= PW'(2)) && (pos_x_ff >= PW'(1)) && (pos_x_ff < cells) &&
                        (pos_y_ff >= PW'(1)) && (pos_y_ff < cells);

   // Next raster position and ring index.
   always_comb begin
      pos_x_in = pos_x_ff + PW'(1);
      pos_y_in = pos_y_ff;
      pos_z_in = pos_z_ff;
      idx_in   = bvpc_pkg::wrap_add(idx_ff, AW'(1));
      if (pos_x_in >= side) begin
         pos_x_in = '0;
         pos_y_in = pos_y_ff + PW'(1);
         if (pos_y_in >= side) begin
            pos_y_in = '0;
            pos_z_in = pos_z_ff + PW'(1);
            if (pos_z_in >= side) begin
               pos_z_in = '0;
               idx_in   = '0;
            end
         end
      end
   end

   // Neighbour address for each read slot.
   always_comb begin
      case (cmd.rd_sel)
         3'd0:    rd_addr = cell_ff;
         3'd1:    rd_addr = bvpc_pkg::wrap_sub(cell_ff, AW'(1));
         3'd2:    rd_addr = bvpc_pkg::wrap_add(cell_ff, AW'(1));
         3'd3:    rd_addr = bvpc_pkg::wrap_sub(cell_ff, side_w);
         3'd4:    rd_addr = bvpc_pkg::wrap_add(cell_ff, side_w);
         3'd5:    rd_addr = bvpc_pkg::wrap_sub(cell_ff, plane_w);
         default: rd_addr = cell_ff;
      endcase
   end

   assign ram_addr = (cmd.step == bvpc_pkg::STEP_READ) ? rd_addr : idx_ff;

   bvpc_ram #(
      .WIDTH (1),
      .DEPTH (bvpc_pkg::WIN_DEPTH)
   ) u_window (
      .clock (clock),
      .we    (sample_beat),
      .addr  (ram_addr),
      .wdata (solid),
      .rdata (ram_rdata)
   );

   // Arithmetic shared by the distance steps.
   assign wsum       = WW'(base_ff[cmd.axis]) + $signed({2'b00, prod_ff});
   assign diff       = DW'(world_ff[cmd.axis]) - DW'(center_ff[cmd.axis]);
   assign mul_a      = (cmd.step == bvpc_pkg::STEP_RSQ) ? radius_ff : mag_ff[31:0];
   assign mul_p      = 64'(mul_a) * 64'(mul_a);
   assign acc_sum    = {1'b0, acc_ff} + {1'b0, sq_ff};
   assign count_next = count_ff + 16'd1;

   // Control state: configuration, raster position and search progress.
   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff[0] <= '0;
         center_ff[1] <= '0;
         center_ff[2] <= '0;
         radius_ff    <= '0;
         pitch_ff     <= 24'd256;
         samples_ff   <= 6'd32;
         max_pts_ff   <= 16'd64;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         pos_z_ff     <= '0;
         idx_ff       <= '0;
         base_ff[0]   <= '0;
         base_ff[1]   <= '0;
         base_ff[2]   <= '0;
         count_ff     <= '0;
         stopped_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               bvpc_pkg::CSR_CENTER_X: center_ff[0] <= csr_wdata;
               bvpc_pkg::CSR_CENTER_Y: center_ff[1] <= csr_wdata;
               bvpc_pkg::CSR_CENTER_Z: center_ff[2] <= csr_wdata;
               bvpc_pkg::CSR_RADIUS:   radius_ff    <= csr_wdata;
               bvpc_pkg::CSR_PITCH:    pitch_ff     <= csr_wdata[23:0];
               bvpc_pkg::CSR_SAMPLES:  samples_ff   <= csr_wdata[5:0];
               bvpc_pkg::CSR_MAX_PTS:  max_pts_ff   <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (cmd.accept && (req_data.kind == bvpc_pkg::KIND_BEGIN)) begin
            count_ff   <= '0;
            stopped_ff <= 1'b0;
         end
         if (cmd.accept && (req_data.kind == bvpc_pkg::KIND_CHUNK)) begin
            base_ff[0] <= req_data.origin_x;
            base_ff[1] <= req_data.origin_y;
            base_ff[2] <= req_data.origin_z;
         end
         if (rewind) begin
            pos_x_ff <= '0;
            pos_y_ff <= '0;
            pos_z_ff <= '0;
            idx_ff   <= '0;
         end else if (sample_beat) begin
            pos_x_ff <= pos_x_in;
            pos_y_ff <= pos_y_in;
            pos_z_ff <= pos_z_in;
            idx_ff   <= idx_in;
         end
         if (cmd.step == bvpc_pkg::STEP_EMIT) begin
            count_ff <= count_next;
            if (count_next >= max_pts_ff) begin
               stopped_ff <= 1'b1;
            end
         end
      end
   end

   // Working registers; they carry payload only and need no reset.
   always_ff @(posedge clock) begin
      if (sample_beat) begin
         coord_ff[0] <= pos_x_ff;
         coord_ff[1] <= pos_y_ff;
         coord_ff[2] <= pos_z_ff - PW'(1);
         interior_ff <= interior;
         self_ff     <= solid;
         cell_ff     <= bvpc_pkg::wrap_sub(idx_ff, plane_w);
      end
      if ((cmd.step == bvpc_pkg::STEP_READ) && (cmd.rd_sel != 3'd0)) begin
         nb_ff[cmd.rd_sel - 3'd1] <= ram_rdata[0];
      end
      case (cmd.step)
         bvpc_pkg::STEP_PROD: begin
            prod_ff <= bvpc_pkg::PROD_W'(coord_ff[cmd.axis]) *
                       bvpc_pkg::PROD_W'(pitch_ff);
            if (cmd.axis == 2'd0) begin
               acc_ff <= '0;
            end
         end
         bvpc_pkg::STEP_WSUM: world_ff[cmd.axis] <= wsum;
         bvpc_pkg::STEP_DIFF: mag_ff <= diff[DW-1] ? DW'(-diff) : DW'(diff);
         bvpc_pkg::STEP_SQR:  sq_ff  <= (mag_ff[DW-1:32] != '0) ? '1 : mul_p;
         bvpc_pkg::STEP_ACCUM: acc_ff <= acc_sum[64] ? '1 : acc_sum[63:0];
         bvpc_pkg::STEP_RSQ:  sq_ff  <= mul_p;
         default: ;
      endcase
   end

   // Result register: each coordinate saturates to the signed 32-bit range.
   function automatic logic [31:0] clamp_world(input logic signed [WW-1:0] w);
      if ((w[WW-1:31] == '0) || (w[WW-1:31] == '1)) begin
         return w[31:0];
      end else if (w[WW-1]) begin
         return 32'h8000_0000;
      end else begin
         return 32'h7FFF_FFFF;
      end
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.step == bvpc_pkg::STEP_EMIT) begin
         rsp_ff.point_x     <= clamp_world(world_ff[0]);
         rsp_ff.point_y     <= clamp_world(world_ff[1]);
         rsp_ff.point_z     <= clamp_world(world_ff[2]);
         rsp_ff.final_point <= (count_next >= max_pts_ff);
      end
   end

   assign rsp_data = rsp_ff;

   // Status towards the controller.
   assign status.sample   = (req_data.kind == bvpc_pkg::KIND_SAMPLE);
   assign status.go       = interior_ff && !nb_ff[0] && ((|nb_ff[5:1]) || self_ff) &&
                            !stopped_ff && (radius_ff > 32'sd0) && (max_pts_ff != 16'd0);
   assign status.in_range = (acc_ff <= sq_ff);

endmodule

>>> rtl/core/bvpc_ctrl.sv
// Controller of the boundary voxel point collector: sequences the neighbour
// reads, the per-axis distance steps and the result handshake.
// Depends on bvpc_pkg.
module bvpc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  bvpc_pkg::status_type status,
   output bvpc_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_PROD,
      ST_WSUM,
      ST_DIFF,
      ST_SQR,
      ST_ACCUM,
      ST_RSQ,
      ST_CMP,
      ST_EMIT
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] axis_ff, axis_in;
   logic [2:0] rd_cnt_ff, rd_cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state and registered outputs.
   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      rd_cnt_in    = rd_cnt_ff;
      // The result beat stays offered until it is taken.
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (accept && status.sample) begin
               state_in  = ST_READ;
               rd_cnt_in = '0;
            end
         end
         ST_READ: begin
            rd_cnt_in = rd_cnt_ff + 3'd1;
            if (rd_cnt_ff == 3'(bvpc_pkg::NB_COUNT)) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            axis_in  = '0;
            state_in = status.go ? ST_PROD : ST_IDLE;
         end
         ST_PROD:  state_in = ST_WSUM;
         ST_WSUM:  state_in = ST_DIFF;
         ST_DIFF:  state_in = ST_SQR;
         ST_SQR:   state_in = ST_ACCUM;
         ST_ACCUM: begin
            if (axis_ff == 2'd2) begin
               state_in = ST_RSQ;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = ST_PROD;
            end
         end
         ST_RSQ:   state_in = ST_CMP;
         // A new point waits here while the previous result beat is pending.
         ST_CMP: begin
            if (!status.in_range) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= '0;
         rd_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         rd_cnt_ff    <= rd_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath command for the current state.
   always_comb begin
      cmd.accept = accept;
      cmd.axis   = axis_ff;
      cmd.rd_sel = rd_cnt_ff;
      case (state_ff)
         ST_READ:  cmd.step = bvpc_pkg::STEP_READ;
         ST_PROD:  cmd.step = bvpc_pkg::STEP_PROD;
         ST_WSUM:  cmd.step = bvpc_pkg::STEP_WSUM;
         ST_DIFF:  cmd.step = bvpc_pkg::STEP_DIFF;
         ST_SQR:   cmd.step = bvpc_pkg::STEP_SQR;
         ST_ACCUM: cmd.step = bvpc_pkg::STEP_ACCUM;
         ST_RSQ:   cmd.step = bvpc_pkg::STEP_RSQ;
         ST_EMIT:  cmd.step = bvpc_pkg::STEP_EMIT;
         default:  cmd.step = bvpc_pkg::STEP_IDLE;
      endcase
   end

endmodule

>>> rtl/core/boundary_voxel_point_collector.sv
// Top level of the boundary voxel point collector.
// Depends on bvpc_pkg, bvpc_ctrl and bvpc_dpath.
//
//   Channel   Handshake                  Payload
//   req       req_valid / req_ready      req_data  (bvpc_pkg::req_type)
//   rsp       rsp_valid / rsp_ready      rsp_data  (bvpc_pkg::rsp_type)
//   csr       csr_we                     csr_index, csr_wdata
//
// Begin-search and chunk-start beats leave the controller idle. A sample beat
// is written to the solid-bit RAM when accepted, then the six neighbours are read
// through the single registered port of that RAM, then comes the boundary check.
// A boundary cell inside the chunk adds per-axis distance work (product, world
// sum, difference, square, accumulate) on one shared multiplier, then the radius
// square, the compare and loading the result register.
// Reset is synchronous and active high; the ring RAM is not cleared.
// The result register frees the request side; only a new point waits at the
// compare while the previous result beat is still held by rsp_ready.
module boundary_voxel_point_collector (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bvpc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bvpc_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_wdata
);

   bvpc_pkg::cmd_type    cmd;
   bvpc_pkg::status_type status;

   bvpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bvpc_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule
